FILE: rtl/psp_pkg.sv
// Shared types and constants for the instruction-pointer stride prefetcher.
`timescale 1ns / 1ps
`default_nettype none

package psp_pkg;

    localparam int ADDR_W   = 48;
    localparam int TAG_W    = 32;
    localparam int STRIDE_W = 32;
    localparam int OCC_W    = 6;
    localparam int CONF_W   = 2;

    typedef logic [CONF_W-1:0] t_conf;

    localparam t_conf CONF_INITIAL   = 2'd0;
    localparam t_conf CONF_TRANSIENT = 2'd1;
    localparam t_conf CONF_STEADY    = 2'd2;
    localparam t_conf CONF_NOPRED    = 2'd3;

    localparam logic [OCC_W-1:0] THRESH_RESET = 6'd8;

    typedef struct packed {
        logic [ADDR_W-1:0] access_addr;
        logic [TAG_W-1:0]  pc_tag;
        logic [OCC_W-1:0]  mshr_occupancy;
    } t_in;

    typedef struct packed {
        logic              issue;
        logic [ADDR_W-1:0] prefetch_addr;
        logic              fill_level;
    } t_out;

    // Contents of the matching entry, as seen by the update logic.
    typedef struct packed {
        logic                hit;
        logic [ADDR_W-1:0]   last_addr;
        logic [STRIDE_W-1:0] stride;
        t_conf               conf;
    } t_look;

    // New contents for the entry that this access touches.
    typedef struct packed {
        logic [ADDR_W-1:0]   last_addr;
        logic [STRIDE_W-1:0] stride;
        t_conf               conf;
    } t_upd;

endpackage

`default_nettype wire

FILE: rtl/psp_table.sv
// Fully associative prediction table: tag match, entry read and entry write.
`timescale 1ns / 1ps
`default_nettype none

module psp_table #(
    parameter int TABLE_ENTRIES = 16,
    parameter int ADDR_BITS     = 48
) (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    input  wire  [psp_pkg::TAG_W-1:0]   i_tag,
    input  wire                         i_we,
    input  psp_pkg::t_upd               i_upd,
    output psp_pkg::t_look              o_look
);
    import psp_pkg::*;

    localparam int LP_AW = (ADDR_BITS < ADDR_W) ? ADDR_BITS : ADDR_W;
    localparam int LP_IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

    logic [TAG_W-1:0]    r_tag    [TABLE_ENTRIES];
    logic [LP_AW-1:0]    r_last   [TABLE_ENTRIES];
    logic [STRIDE_W-1:0] r_stride [TABLE_ENTRIES];
    t_conf               r_conf   [TABLE_ENTRIES];
    logic [LP_IW-1:0]    r_alloc;

    logic [TABLE_ENTRIES-1:0] match;
    logic [LP_IW-1:0]         hit_idx;
    logic                     hit;
    logic [LP_IW-1:0]         wr_idx;
    logic [LP_IW-1:0]         n_alloc;

    always_comb begin
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
            match[i] = (r_tag[i] == i_tag);
        end
    end

    // The lowest-numbered matching entry wins.
    always_comb begin
        hit_idx = '0;
        for (int i = TABLE_ENTRIES - 1; i >= 0; i--) begin
            if (match[i]) begin
                hit_idx = LP_IW'(i);
            end
        end
    end

    assign hit = |match;

    assign o_look.hit       = hit;
    assign o_look.last_addr = ADDR_W'(r_last[hit_idx]);
    assign o_look.stride    = r_stride[hit_idx];
    assign o_look.conf      = r_conf[hit_idx];

    assign wr_idx  = hit ? hit_idx : r_alloc;
    assign n_alloc = (r_alloc == LP_IW'(TABLE_ENTRIES - 1)) ? '0 : r_alloc + 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < TABLE_ENTRIES; i++) begin
                r_tag[i]    <= '0;
                r_last[i]   <= '0;
                r_stride[i] <= '0;
                r_conf[i]   <= CONF_INITIAL;
            end
            r_alloc <= '0;
        end else if (i_we) begin
            r_tag[wr_idx]    <= i_tag;
            r_last[wr_idx]   <= i_upd.last_addr[LP_AW-1:0];
            r_stride[wr_idx] <= i_upd.stride;
            r_conf[wr_idx]   <= i_upd.conf;
            if (!hit) begin
                r_alloc <= n_alloc;
            end
        end
    end

endmodule

`default_nettype wire

FILE: rtl/psp_next.sv
// Stride and confidence update for one access, and the prefetch it produces.
`timescale 1ns / 1ps
`default_nettype none

module psp_next #(
    parameter int ADDR_BITS = 48
) (
    input  psp_pkg::t_in                i_in,
    input  psp_pkg::t_look              i_look,
    input  wire  [psp_pkg::OCC_W-1:0]   i_threshold,
    output psp_pkg::t_upd               o_upd,
    output psp_pkg::t_out               o_out
);
    import psp_pkg::*;

    localparam int LP_AW = (ADDR_BITS < ADDR_W) ? ADDR_BITS : ADDR_W;

    logic [LP_AW-1:0]    addr;
    logic [LP_AW-1:0]    diff;
    logic [STRIDE_W-1:0] stride_now;
    logic                same;
    logic [STRIDE_W-1:0] n_stride;
    t_conf               n_conf;
    logic [LP_AW-1:0]    pf_sum;

    assign addr       = i_in.access_addr[LP_AW-1:0];
    assign diff       = addr - i_look.last_addr[LP_AW-1:0];
    assign stride_now = diff[STRIDE_W-1:0];
    assign same       = (stride_now == i_look.stride);

    always_comb begin
        n_stride = i_look.stride;
        n_conf   = i_look.conf;
        if (!i_look.hit) begin
            // Newly allocated entry starts afresh.
            n_stride = '0;
            n_conf   = CONF_INITIAL;
        end else begin
            unique case (i_look.conf)
                CONF_INITIAL: begin
                    if (same) begin
                        n_conf = CONF_STEADY;
                    end else begin
                        n_conf   = CONF_TRANSIENT;
                        n_stride = stride_now;
                    end
                end
                CONF_TRANSIENT: begin
                    if (same) begin
                        n_conf = CONF_STEADY;
                    end else begin
                        n_conf   = CONF_NOPRED;
                        n_stride = stride_now;
                    end
                end
                CONF_STEADY: begin
                    if (!same) begin
                        n_conf = CONF_INITIAL;
                    end
                end
                CONF_NOPRED: begin
                    if (same) begin
                        n_conf = CONF_TRANSIENT;
                    end else begin
                        n_stride = stride_now;
                    end
                end
                default: begin
                    n_conf = CONF_INITIAL;
                end
            endcase
        end
    end

    assign o_upd.last_addr = ADDR_W'(addr);
    assign o_upd.stride    = n_stride;
    assign o_upd.conf      = n_conf;

    // The stride is signed, so it is sign-extended before the wrapping add.
    assign pf_sum = addr + LP_AW'($signed(n_stride));

    always_comb begin
        o_out = '0;
        if (n_conf == CONF_STEADY) begin
            o_out.issue         = 1'b1;
            o_out.prefetch_addr = ADDR_W'(pf_sum);
            o_out.fill_level    = (i_in.mshr_occupancy > i_threshold);
        end
    end

endmodule

`default_nettype wire

FILE: rtl/pc_stride_prefetcher.sv
// Top level of the instruction-pointer stride prefetcher.
//
//  Channel   Signals                              Beat carries
//  -------   ----------------------------------   ------------------------------
//  in        i_in_valid / o_in_ready / i_in_data  one cache access (t_in)
//  out       o_out_valid / i_out_ready / o_out_data  one prefetch decision (t_out)
//  cfg       i_cfg_valid / o_cfg_ready / i_cfg_data  MSHR threshold, always ready
//
// An access is registered on entry and resolved from that input register: tag match,
// table update and result all happen in one pass into the output register, which
// offers the result; while the output is free, one beat per cycle is sustained.
// Reset is synchronous and clears the whole table, the allocation pointer and
// the threshold (to 8). When the output is stalled the input register holds its
// beat and the table is not touched until that beat can move on.
`timescale 1ns / 1ps
`default_nettype none

module pc_stride_prefetcher #(
    parameter int TABLE_ENTRIES = 16,
    parameter int ADDR_BITS     = 48
) (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    input  wire                         i_in_valid,
    output logic                        o_in_ready,
    input  psp_pkg::t_in                i_in_data,
    output logic                        o_out_valid,
    input  wire                         i_out_ready,
    output psp_pkg::t_out               o_out_data,
    input  wire                         i_cfg_valid,
    output logic                        o_cfg_ready,
    input  wire  [psp_pkg::OCC_W-1:0]   i_cfg_data
);
    import psp_pkg::*;

    logic             r_in_valid;
    t_in              r_in;
    logic             r_out_valid;
    t_out             r_out;
    logic [OCC_W-1:0] r_threshold;

    logic  out_free;
    logic  fire;
    t_look look;
    t_upd  upd;
    t_out  res;

    assign out_free   = !r_out_valid || i_out_ready;
    assign fire       = r_in_valid && out_free;
    assign o_in_ready = !r_in_valid || fire;
    assign o_cfg_ready = 1'b1;

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    psp_table #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .ADDR_BITS     (ADDR_BITS)
    ) u_table (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_tag   (r_in.pc_tag),
        .i_we    (fire),
        .i_upd   (upd),
        .o_look  (look)
    );

    psp_next #(
        .ADDR_BITS (ADDR_BITS)
    ) u_next (
        .i_in        (r_in),
        .i_look      (look),
        .i_threshold (r_threshold),
        .o_upd       (upd),
        .o_out       (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_threshold <= THRESH_RESET;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (out_free) begin
                r_out_valid <= fire;
            end
            if (i_cfg_valid) begin
                r_threshold <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in <= i_in_data;
        end
        if (fire) begin
            r_out <= res;
        end
    end

endmodule

`default_nettype wire

FILE: sim/pc_stride_prefetcher_tb.sv
// Self-checking testbench for the instruction-pointer stride prefetcher.
`timescale 1ns / 1ps

module pc_stride_prefetcher_tb;
    import psp_pkg::*;

    localparam int RPT_ENTRIES = 16;
    localparam int NSTREAMS    = 12;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               in_valid = 1'b0;
    t_in                in_data = '0;
    logic               out_ready = 1'b0;
    logic               cfg_valid = 1'b0;
    logic [OCC_W-1:0]   cfg_data = '0;
    wire                o_in_ready;
    wire                o_out_valid;
    wire                o_cfg_ready;
    t_out               o_out_data;

    pc_stride_prefetcher #(
        .TABLE_ENTRIES (RPT_ENTRIES),
        .ADDR_BITS     (ADDR_W)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // Accesses waiting to be offered, and prefetch decisions still owed by the block.
    t_in  access_backlog[$];
    t_out prefetch_due[$];

    int   err_count = 0;
    int   result_count = 0;
    int   send_idle_pct = 0;
    int   recv_stall_pct = 0;
    logic hold_kick = 1'b0;
    int   hold_left = 0;

    // Shadow of the prediction table and the threshold register.
    logic [TAG_W-1:0]    rpt_tag[RPT_ENTRIES];
    logic [ADDR_W-1:0]   rpt_last[RPT_ENTRIES];
    logic [STRIDE_W-1:0] rpt_stride[RPT_ENTRIES];
    t_conf               rpt_conf[RPT_ENTRIES];
    int                  rpt_alloc = 0;
    logic [OCC_W-1:0]    shadow_threshold = THRESH_RESET;

    // Random access streams, each a run of addresses at a fixed stride from one tag.
    logic [TAG_W-1:0]    strm_tag[NSTREAMS];
    logic [ADDR_W-1:0]   strm_addr[NSTREAMS];
    logic [STRIDE_W-1:0] strm_stride[NSTREAMS];

    initial begin
        for (int i = 0; i < RPT_ENTRIES; i++) begin
            rpt_tag[i]    = '0;
            rpt_last[i]   = '0;
            rpt_stride[i] = '0;
            rpt_conf[i]   = CONF_INITIAL;
        end
    end

    task automatic report_mismatch(input string msg);
        $display("ERROR @%0t: %s", $realtime, msg);
        err_count++;
    endtask

    function automatic t_out predict_prefetch(input t_in acc);
        t_out                res;
        logic                hit;
        int                  idx;
        logic [ADDR_W-1:0]   delta;
        logic [STRIDE_W-1:0] stride_now;
        logic                same;
        hit = 1'b0;
        idx = 0;
        res = '0;
        for (int i = 0; i < RPT_ENTRIES; i++) begin
            if (!hit && rpt_tag[i] == acc.pc_tag) begin
                hit = 1'b1;
                idx = i;
            end
        end
        if (hit) begin
            delta      = acc.access_addr - rpt_last[idx];
            stride_now = delta[STRIDE_W-1:0];
            same       = (stride_now == rpt_stride[idx]);
            case (rpt_conf[idx])
                CONF_INITIAL: begin
                    if (same) begin
                        rpt_conf[idx] = CONF_STEADY;
                    end else begin
                        rpt_conf[idx]   = CONF_TRANSIENT;
                        rpt_stride[idx] = stride_now;
                    end
                end
                CONF_TRANSIENT: begin
                    if (same) begin
                        rpt_conf[idx] = CONF_STEADY;
                    end else begin
                        rpt_conf[idx]   = CONF_NOPRED;
                        rpt_stride[idx] = stride_now;
                    end
                end
                CONF_STEADY: begin
                    if (!same) rpt_conf[idx] = CONF_INITIAL;
                end
                default: begin
                    if (same) rpt_conf[idx] = CONF_TRANSIENT;
                    else rpt_stride[idx] = stride_now;
                end
            endcase
            rpt_last[idx] = acc.access_addr;
        end else begin
            idx = rpt_alloc;
            rpt_alloc = (rpt_alloc == RPT_ENTRIES - 1) ? 0 : rpt_alloc + 1;
            rpt_tag[idx]    = acc.pc_tag;
            rpt_last[idx]   = acc.access_addr;
            rpt_stride[idx] = '0;
            rpt_conf[idx]   = CONF_INITIAL;
        end
        if (rpt_conf[idx] == CONF_STEADY) begin
            res.issue         = 1'b1;
            res.prefetch_addr = acc.access_addr
                              + {{(ADDR_W-STRIDE_W){rpt_stride[idx][STRIDE_W-1]}},
                                 rpt_stride[idx]};
            res.fill_level    = (acc.mshr_occupancy > shadow_threshold);
        end
        return res;
    endfunction

    // Driver: predicts each beat as it is accepted, then offers the next one.
    always @(posedge i_clk) begin
        logic nxt_valid;
        t_in  nxt_data;
        nxt_valid = in_valid;
        nxt_data  = in_data;
        if (!i_rst_n) begin
            nxt_valid = 1'b0;
        end else begin
            if (in_valid && o_in_ready) begin
                prefetch_due.push_back(predict_prefetch(in_data));
                nxt_valid = 1'b0;
            end
            if (!nxt_valid && access_backlog.size() != 0
                && $urandom_range(0, 99) >= send_idle_pct) begin
                nxt_valid = 1'b1;
                nxt_data  = access_backlog.pop_front();
            end
        end
        in_valid <= nxt_valid;
        in_data  <= nxt_data;
    end

    // Long receiver hold-off, counted down on its own.
    always @(posedge i_clk) begin
        if (hold_kick) begin
            hold_left <= 300;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // Monitor: checks every output beat against the oldest outstanding prediction.
    always @(posedge i_clk) begin
        t_out want;
        if (i_rst_n && o_out_valid && out_ready) begin
            if (prefetch_due.size() == 0) begin
                report_mismatch($sformatf("result %0d arrived with nothing outstanding",
                                          result_count));
            end else begin
                want = prefetch_due.pop_front();
                if (o_out_data.issue !== want.issue) begin
                    report_mismatch($sformatf("result %0d issue got %b want %b",
                                              result_count, o_out_data.issue, want.issue));
                end
                if (o_out_data.prefetch_addr !== want.prefetch_addr) begin
                    report_mismatch($sformatf("result %0d prefetch_addr got %h want %h",
                                              result_count, o_out_data.prefetch_addr,
                                              want.prefetch_addr));
                end
                if (o_out_data.fill_level !== want.fill_level) begin
                    report_mismatch($sformatf("result %0d fill_level got %b want %b",
                                              result_count, o_out_data.fill_level,
                                              want.fill_level));
                end
            end
            result_count++;
        end
        out_ready <= (hold_left == 0) && ($urandom_range(0, 99) >= recv_stall_pct);
    end

    task automatic queue_access(input logic [ADDR_W-1:0] addr, input logic [TAG_W-1:0] tag,
                                input logic [OCC_W-1:0] occ);
        t_in acc;
        acc.access_addr    = addr;
        acc.pc_tag         = tag;
        acc.mshr_occupancy = occ;
        access_backlog.push_back(acc);
    endtask

    function automatic logic [ADDR_W-1:0] rand_addr();
        logic [63:0] r;
        r = {$urandom(), $urandom()};
        return r[ADDR_W-1:0];
    endfunction

    function automatic logic [STRIDE_W-1:0] rand_stride();
        logic [STRIDE_W-1:0] s;
        case ($urandom_range(0, 3))
            0: s = ($urandom_range(0, 64) - 32) * 64;
            1: s = $urandom();
            2: s = '0;
            default: s = $urandom_range(0, 16) - 8;
        endcase
        return s;
    endfunction

    task automatic seed_stream(input int k);
        strm_tag[k]    = $urandom();
        strm_addr[k]   = rand_addr();
        strm_stride[k] = rand_stride();
        // Now and then start just below the top so the prefetch address wraps.
        if ($urandom_range(0, 3) == 0) strm_addr[k][ADDR_W-1:12] = '1;
    endtask

    // Mostly well-formed strided runs; the rest breaks runs, changes strides or is noise.
    task automatic queue_random_accesses(input int n);
        int k;
        int r;
        repeat (n) begin
            k = $urandom_range(0, NSTREAMS - 1);
            r = $urandom_range(0, 99);
            if (r < 3) begin
                seed_stream(k);
            end else if (r < 12) begin
                queue_access(rand_addr(), $urandom(), OCC_W'($urandom_range(0, 63)));
                continue;
            end else if (r < 20) begin
                strm_addr[k] = rand_addr();
            end else begin
                if (r < 25) strm_stride[k] = rand_stride();
                strm_addr[k] = strm_addr[k]
                             + {{(ADDR_W-STRIDE_W){strm_stride[k][STRIDE_W-1]}},
                                strm_stride[k]};
            end
            queue_access(strm_addr[k], strm_tag[k], OCC_W'($urandom_range(0, 63)));
        end
    endtask

    task automatic write_threshold(input logic [OCC_W-1:0] value);
        @(posedge i_clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        shadow_threshold = value;
        cfg_valid <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic wait_drained();
        do @(negedge i_clk);
        while (access_backlog.size() != 0 || in_valid || prefetch_due.size() != 0);
    endtask

    initial begin
        for (int k = 0; k < NSTREAMS; k++) seed_stream(k);
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed beats under the reset threshold of 8.
        // Tag zero hits entry 0 after reset, whose last address is zero.
        queue_access(48'h0000_0000_0040, 32'h0, 6'd0);
        queue_access(48'h0000_0000_0080, 32'h0, 6'd9);
        queue_access(48'h0000_0000_00C0, 32'h0, 6'd8);
        queue_access(48'h0000_0000_0000, 32'h0, 6'd63);
        // New tag takes entry 0; the stride run wraps past the top of the address space.
        queue_access(48'hFFFF_FFFF_FF00, 32'hFFFF_FFFF, 6'd0);
        queue_access(48'hFFFF_FFFF_FF80, 32'hFFFF_FFFF, 6'd1);
        queue_access(48'h0000_0000_0000, 32'hFFFF_FFFF, 6'd63);
        // Tag zero now matches entry 1, the lowest of the remaining zero tags.
        queue_access(48'h0000_0000_1000, 32'h0, 6'd20);
        queue_access(48'h0000_0000_2000, 32'h0, 6'd7);
        // Negative stride.
        queue_access(48'h8000_0000_0000, 32'h1234_5678, 6'd32);
        queue_access(48'h7FFF_FFFF_FFC0, 32'h1234_5678, 6'd31);
        queue_access(48'h7FFF_FFFF_FF80, 32'h1234_5678, 6'd62);
        // Address steps wider than 32 bits leave only the low word as the stride.
        queue_access(48'h0000_0000_0000, 32'hA5A5_A5A5, 6'd5);
        queue_access(48'h0001_0000_0040, 32'hA5A5_A5A5, 6'd10);
        queue_access(48'h0002_0000_0080, 32'h5A5A_5A5A, 6'd10);
        queue_access(48'h0003_0000_00C0, 32'hA5A5_A5A5, 6'd42);
        // Through the no-prediction state and back up to steady.
        queue_access(48'h5555_5555_5100, 32'h5A5A_5A5A, 6'd3);
        queue_access(48'h5555_5555_5110, 32'h5A5A_5A5A, 6'd3);
        queue_access(48'h5555_5555_5200, 32'h5A5A_5A5A, 6'd3);
        queue_access(48'h5555_5555_52F0, 32'h5A5A_5A5A, 6'd3);
        queue_access(48'h5555_5555_53E0, 32'h5A5A_5A5A, 6'd12);
        // A zero stride matches the fresh entry at once.
        queue_access(48'hAAAA_AAAA_A500, 32'h0F0F_0F0F, 6'd0);
        queue_access(48'hAAAA_AAAA_A500, 32'h0F0F_0F0F, 6'd63);
        wait_drained();

        // Threshold at its floor, no idling, and one long output hold-off so that
        // the block backs up and refuses input beats.
        write_threshold(6'd0);
        queue_random_accesses(180);
        @(posedge i_clk);
        hold_kick <= 1'b1;
        @(posedge i_clk);
        hold_kick <= 1'b0;
        wait_drained();

        write_threshold(6'd63);
        send_idle_pct = 67;
        queue_random_accesses(180);
        wait_drained();

        write_threshold(6'($urandom_range(1, 62)));
        send_idle_pct  = 0;
        recv_stall_pct = 67;
        queue_random_accesses(180);
        wait_drained();

        write_threshold(6'($urandom_range(1, 62)));
        send_idle_pct  = 18;
        recv_stall_pct = 18;
        queue_random_accesses(190);
        wait_drained();

        repeat (10) @(posedge i_clk);
        if (err_count == 0 && prefetch_due.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("Timeout waiting for the block to drain");
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

FILE: files.f
rtl/psp_pkg.sv
rtl/psp_table.sv
rtl/psp_next.sv
rtl/pc_stride_prefetcher.sv
sim/pc_stride_prefetcher_tb.sv
